// ===== rtl/tnfp_pkg.sv =====
// ============================================================================
// tnfp_pkg: shared types and constants of the two-node first-fit placer
// Operation, status and node codes, the host entry layout and the
// saturating credit used on release.
// ============================================================================
package tnfp_pkg;

   localparam int unsigned AMT_W  = 11;
   localparam int unsigned HOST_W = 8;

   localparam logic [AMT_W-1:0] CAP_LIMIT = 11'd1024;

   localparam logic [1:0] OP_PLACE   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_ADD     = 2'd2;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_UNUSED = 2'd3;

   localparam logic [1:0] NODE_A    = 2'd0;
   localparam logic [1:0] NODE_B    = 2'd1;
   localparam logic [1:0] NODE_BOTH = 2'd2;

   typedef struct packed {
      logic [AMT_W-1:0] cores_a;
      logic [AMT_W-1:0] cores_b;
      logic [AMT_W-1:0] mem_a;
      logic [AMT_W-1:0] mem_b;
   } entry_type;

   typedef struct packed {
      logic       fit;
      logic [1:0] where;
      entry_type  entry;
   } alu_result_type;

   function automatic logic [AMT_W-1:0] credit(logic [AMT_W-1:0] have,
                                               logic [AMT_W-1:0] amount);
      logic [AMT_W:0] sum;
      sum = {1'b0, have} + {1'b0, amount};
      return (sum > {1'b0, CAP_LIMIT}) ? CAP_LIMIT : sum[AMT_W-1:0];
   endfunction

endpackage

// ===== rtl/tnfp_table.sv =====
// ============================================================================
// tnfp_table: host capacity table
// One write port and one read port with registered read data; each word
// holds the free cores and free memory of both nodes of a host.
// ============================================================================
module tnfp_table #(
   parameter int unsigned HOSTS = 256,
   parameter int unsigned AW    = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  tnfp_pkg::entry_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output tnfp_pkg::entry_type rd_data
);

   tnfp_pkg::entry_type mem [HOSTS];
   tnfp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tnfp_alu.sv =====
// ============================================================================
// tnfp_alu: fit check and update unit
// Tests one host entry against a place request and forms the debited
// entry, or forms the credited entry of a release.
// ============================================================================
module tnfp_alu (
   input  logic [1:0]                     operation,
   input  logic [tnfp_pkg::AMT_W-1:0]     cores,
   input  logic [tnfp_pkg::AMT_W-1:0]     memories,
   input  logic                           dual,
   input  logic [1:0]                     release_where,
   input  tnfp_pkg::entry_type            entry_in,
   output tnfp_pkg::alu_result_type       result
);

   logic [tnfp_pkg::AMT_W-1:0] half_cores;
   logic [tnfp_pkg::AMT_W-1:0] half_mem;
   logic                       fit_a;
   logic                       fit_b;
   logic                       fit_dual;

   assign half_cores = cores >> 1;
   assign half_mem   = memories >> 1;

   assign fit_dual = (entry_in.cores_a >= half_cores) && (entry_in.cores_b >= half_cores) &&
                     (entry_in.mem_a >= half_mem) && (entry_in.mem_b >= half_mem);
   assign fit_a    = (entry_in.cores_a > entry_in.cores_b) &&
                     (entry_in.cores_a >= cores) && (entry_in.mem_a >= memories);
   assign fit_b    = (entry_in.cores_b >= cores) && (entry_in.mem_b >= memories);

   always_comb begin
      result.fit   = 1'b0;
      result.where = tnfp_pkg::NODE_B;
      result.entry = entry_in;
      if (operation == tnfp_pkg::OP_RELEASE) begin
         result.fit = 1'b1;
         case (release_where)
            tnfp_pkg::NODE_BOTH: begin
               result.where         = tnfp_pkg::NODE_BOTH;
               result.entry.cores_a = tnfp_pkg::credit(entry_in.cores_a, half_cores);
               result.entry.cores_b = tnfp_pkg::credit(entry_in.cores_b, half_cores);
               result.entry.mem_a   = tnfp_pkg::credit(entry_in.mem_a, half_mem);
               result.entry.mem_b   = tnfp_pkg::credit(entry_in.mem_b, half_mem);
            end
            tnfp_pkg::NODE_A: begin
               result.where         = tnfp_pkg::NODE_A;
               result.entry.cores_a = tnfp_pkg::credit(entry_in.cores_a, cores);
               result.entry.mem_a   = tnfp_pkg::credit(entry_in.mem_a, memories);
            end
            default: begin
               result.where         = tnfp_pkg::NODE_B;
               result.entry.cores_b = tnfp_pkg::credit(entry_in.cores_b, cores);
               result.entry.mem_b   = tnfp_pkg::credit(entry_in.mem_b, memories);
            end
         endcase
      end else if (dual) begin
         result.fit           = fit_dual;
         result.where         = tnfp_pkg::NODE_BOTH;
         result.entry.cores_a = entry_in.cores_a - half_cores;
         result.entry.cores_b = entry_in.cores_b - half_cores;
         result.entry.mem_a   = entry_in.mem_a - half_mem;
         result.entry.mem_b   = entry_in.mem_b - half_mem;
      end else if (fit_a) begin
         result.fit           = 1'b1;
         result.where         = tnfp_pkg::NODE_A;
         result.entry.cores_a = entry_in.cores_a - cores;
         result.entry.mem_a   = entry_in.mem_a - memories;
      end else begin
         result.fit           = fit_b;
         result.where         = tnfp_pkg::NODE_B;
         result.entry.cores_b = entry_in.cores_b - cores;
         result.entry.mem_b   = entry_in.mem_b - memories;
      end
   end

endmodule

// ===== rtl/two_node_first_fit_placer_unit.sv =====
// ============================================================================
// two_node_first_fit_placer_unit: first-fit placer over two-node hosts
// Sequencer that scans the host table through one fit/update unit.
// ============================================================================
// Add host, table full, unused index, unknown operation and place on an empty
// table answer in the cycle after the transfer; release answers after the REL
// state; place after scanning the hosts in order (at most the host count, HOSTS).
// Throughput: one item at a time, busy high while a scan or release runs;
// the scan visits one table entry per cycle through the table read port.
// Reset clears the host count and control state; the table needs no clear.
// ============================================================================
module two_node_first_fit_placer_unit #(
   parameter int unsigned HOSTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [10:0] req_cores,
   input  logic [10:0] req_memories,
   input  logic        req_dual,
   input  logic [7:0]  req_host_index,
   input  logic [1:0]  req_release_where,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_placed_host,
   output logic [1:0]  rsp_placed_where
);

   localparam int unsigned AW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
   localparam int unsigned CW = $clog2(HOSTS + 1);

   typedef enum logic [1:0] {IDLE, SCAN, REL} state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] cur_ff;
   logic [1:0]  op_ff;
   logic [10:0] cores_ff;
   logic [10:0] mem_ff;
   logic        dual_ff;
   logic [7:0]  idx_ff;
   logic [1:0]  where_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_host_ff;
   logic [1:0]  rsp_where_ff;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   tnfp_pkg::entry_type      wr_data;
   tnfp_pkg::entry_type      add_entry;
   logic [AW-1:0]            rd_addr;
   tnfp_pkg::entry_type      rd_data;
   tnfp_pkg::alu_result_type alu;

   logic [AW+7:0] req_idx_ext;
   logic [AW+7:0] idx_ext;
   logic [AW+7:0] cur_ext;
   logic [CW+7:0] count_ext;
   logic          idx_unused;
   logic          table_full;
   logic          last_host;

   assign req_idx_ext = {{AW{1'b0}}, req_host_index};
   assign idx_ext     = {{AW{1'b0}}, idx_ff};
   assign cur_ext     = {8'd0, cur_ff};
   assign count_ext   = {8'd0, count_ff};
   assign idx_unused  = {{CW{1'b0}}, req_host_index} >= count_ext;
   assign table_full  = count_ff == CW'(HOSTS);
   assign last_host   = CW'(cur_ff) == (count_ff - CW'(1));

   assign add_entry.cores_a = req_cores >> 1;
   assign add_entry.cores_b = req_cores >> 1;
   assign add_entry.mem_a   = req_memories >> 1;
   assign add_entry.mem_b   = req_memories >> 1;

   tnfp_alu u_alu (
      .operation     (op_ff),
      .cores         (cores_ff),
      .memories      (mem_ff),
      .dual          (dual_ff),
      .release_where (where_ff),
      .entry_in      (rd_data),
      .result        (alu)
   );

   tnfp_table #(
      .HOSTS (HOSTS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = alu.entry;
      rd_addr = cur_ff + AW'(1);
      unique case (state_ff)
         IDLE: begin
            rd_addr = (req_operation == tnfp_pkg::OP_RELEASE) ? req_idx_ext[AW-1:0] : '0;
            if (start && (req_operation == tnfp_pkg::OP_ADD) && !table_full) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[AW-1:0];
               wr_data = add_entry;
            end
         end
         SCAN: begin
            wr_en = alu.fit;
         end
         REL: begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[AW-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  op_ff    <= req_operation;
                  cores_ff <= req_cores;
                  mem_ff   <= req_memories;
                  dual_ff  <= req_dual;
                  idx_ff   <= req_host_index;
                  where_ff <= req_release_where;
                  unique case (req_operation)
                     tnfp_pkg::OP_PLACE: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= tnfp_pkg::ST_NOFIT;
                           rsp_host_ff   <= '0;
                           rsp_where_ff  <= tnfp_pkg::NODE_A;
                        end else begin
                           cur_ff   <= '0;
                           state_ff <= SCAN;
                        end
                     end
                     tnfp_pkg::OP_RELEASE: begin
                        if (idx_unused) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= tnfp_pkg::ST_UNUSED;
                           rsp_host_ff   <= req_host_index;
                           rsp_where_ff  <= tnfp_pkg::NODE_A;
                        end else begin
                           state_ff <= REL;
                        end
                     end
                     tnfp_pkg::OP_ADD: begin
                        rsp_valid_ff <= 1'b1;
                        if (table_full) begin
                           rsp_status_ff <= tnfp_pkg::ST_FULL;
                           rsp_host_ff   <= '0;
                           rsp_where_ff  <= tnfp_pkg::NODE_A;
                        end else begin
                           rsp_status_ff <= tnfp_pkg::ST_DONE;
                           rsp_host_ff   <= count_ext[7:0];
                           rsp_where_ff  <= tnfp_pkg::NODE_BOTH;
                           count_ff      <= count_ff + CW'(1);
                        end
                     end
                     default: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= tnfp_pkg::ST_DONE;
                        rsp_host_ff   <= '0;
                        rsp_where_ff  <= tnfp_pkg::NODE_A;
                     end
                  endcase
               end
            end
            SCAN: begin
               if (alu.fit) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= tnfp_pkg::ST_DONE;
                  rsp_host_ff   <= cur_ext[7:0];
                  rsp_where_ff  <= alu.where;
                  state_ff      <= IDLE;
               end else if (last_host) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= tnfp_pkg::ST_NOFIT;
                  rsp_host_ff   <= '0;
                  rsp_where_ff  <= tnfp_pkg::NODE_A;
                  state_ff      <= IDLE;
               end else begin
                  cur_ff <= cur_ff + AW'(1);
               end
            end
            REL: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= tnfp_pkg::ST_DONE;
               rsp_host_ff   <= idx_ff;
               rsp_where_ff  <= alu.where;
               state_ff      <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy             = state_ff != IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_placed_host  = rsp_host_ff;
   assign rsp_placed_where = rsp_where_ff;

endmodule

// ===== test/two_node_first_fit_placer_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// two_node_first_fit_placer_unit_tb: self-checking bench for the placer
// Drives place, release, add-host and unknown commands through the start/busy port.
// A local copy of the host table predicts every response, and each response
// strobe is checked field by field. The bench grows the table, fills it, and
// then runs traffic on a full table, with random gaps between transfers.
// ============================================================================
module two_node_first_fit_placer_unit_tb;

   localparam int unsigned TABLE_SIZE   = 256;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 300;

   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [1:0] NODE_ALT_B = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [10:0] cores;
      logic [10:0] memories;
      logic        dual;
      logic [7:0]  host_index;
      logic [1:0]  release_where;
   } request_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] host;
      logic [1:0] where;
   } outcome_type;

   typedef struct packed {
      logic [7:0]  host;
      logic [1:0]  where;
      logic [10:0] cores;
      logic [10:0] mem;
   } holding_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [10:0] req_cores;
   logic [10:0] req_memories;
   logic        req_dual;
   logic [7:0]  req_host_index;
   logic [1:0]  req_release_where;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_placed_host;
   logic [1:0]  rsp_placed_where;

   logic [10:0] free_cores_a [TABLE_SIZE];
   logic [10:0] free_cores_b [TABLE_SIZE];
   logic [10:0] free_mem_a   [TABLE_SIZE];
   logic [10:0] free_mem_b   [TABLE_SIZE];
   int unsigned hosts_added;

   outcome_type outcomes_due [$];
   holding_type placements_held [$];
   int unsigned mismatches;
   int unsigned idle_cycles;
   bit          no_idle;

   two_node_first_fit_placer_unit #(
      .HOSTS(TABLE_SIZE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_cores(req_cores),
      .req_memories(req_memories),
      .req_dual(req_dual),
      .req_host_index(req_host_index),
      .req_release_where(req_release_where),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_placed_host(rsp_placed_host),
      .rsp_placed_where(rsp_placed_where)
   );

   always #1 clock = ~clock;

   function automatic logic [10:0] capped_sum(logic [10:0] have, logic [10:0] amount);
      logic [11:0] total;
      total = {1'b0, have} + {1'b0, amount};
      return (total > {1'b0, tnfp_pkg::CAP_LIMIT}) ? tnfp_pkg::CAP_LIMIT : total[10:0];
   endfunction

   task automatic apply_to_table(input request_type rq, output outcome_type oc);
      logic [10:0] half_c;
      logic [10:0] half_m;
      int unsigned idx;
      holding_type held;
      half_c = rq.cores >> 1;
      half_m = rq.memories >> 1;
      oc = '0;
      case (rq.op)
         tnfp_pkg::OP_PLACE: begin
            oc.status = tnfp_pkg::ST_NOFIT;
            for (int unsigned i = 0; i < hosts_added; i++) begin
               if (rq.dual) begin
                  if (free_cores_a[i] >= half_c && free_cores_b[i] >= half_c &&
                      free_mem_a[i] >= half_m && free_mem_b[i] >= half_m) begin
                     free_cores_a[i] -= half_c;
                     free_cores_b[i] -= half_c;
                     free_mem_a[i]   -= half_m;
                     free_mem_b[i]   -= half_m;
                     oc = '{status: tnfp_pkg::ST_DONE, host: 8'(i),
                            where: tnfp_pkg::NODE_BOTH};
                     break;
                  end
               end else if (free_cores_a[i] > free_cores_b[i] &&
                            free_cores_a[i] >= rq.cores && free_mem_a[i] >= rq.memories) begin
                  free_cores_a[i] -= rq.cores;
                  free_mem_a[i]   -= rq.memories;
                  oc = '{status: tnfp_pkg::ST_DONE, host: 8'(i), where: tnfp_pkg::NODE_A};
                  break;
               end else if (free_cores_b[i] >= rq.cores && free_mem_b[i] >= rq.memories) begin
                  free_cores_b[i] -= rq.cores;
                  free_mem_b[i]   -= rq.memories;
                  oc = '{status: tnfp_pkg::ST_DONE, host: 8'(i), where: tnfp_pkg::NODE_B};
                  break;
               end
            end
            if (oc.status == tnfp_pkg::ST_DONE) begin
               held = '{host: oc.host, where: oc.where, cores: rq.cores, mem: rq.memories};
               placements_held = {placements_held, held};
            end
         end
         tnfp_pkg::OP_RELEASE: begin
            idx = rq.host_index;
            oc.host = rq.host_index;
            if (idx >= hosts_added) begin
               oc.status = tnfp_pkg::ST_UNUSED;
            end else if (rq.release_where == tnfp_pkg::NODE_BOTH) begin
               free_cores_a[idx] = capped_sum(free_cores_a[idx], half_c);
               free_cores_b[idx] = capped_sum(free_cores_b[idx], half_c);
               free_mem_a[idx]   = capped_sum(free_mem_a[idx], half_m);
               free_mem_b[idx]   = capped_sum(free_mem_b[idx], half_m);
               oc.where = tnfp_pkg::NODE_BOTH;
            end else if (rq.release_where == tnfp_pkg::NODE_A) begin
               free_cores_a[idx] = capped_sum(free_cores_a[idx], rq.cores);
               free_mem_a[idx]   = capped_sum(free_mem_a[idx], rq.memories);
               oc.where = tnfp_pkg::NODE_A;
            end else begin
               free_cores_b[idx] = capped_sum(free_cores_b[idx], rq.cores);
               free_mem_b[idx]   = capped_sum(free_mem_b[idx], rq.memories);
               oc.where = tnfp_pkg::NODE_B;
            end
         end
         tnfp_pkg::OP_ADD: begin
            if (hosts_added >= TABLE_SIZE) begin
               oc.status = tnfp_pkg::ST_FULL;
            end else begin
               free_cores_a[hosts_added] = half_c;
               free_cores_b[hosts_added] = half_c;
               free_mem_a[hosts_added]   = half_m;
               free_mem_b[hosts_added]   = half_m;
               oc = '{status: tnfp_pkg::ST_DONE, host: 8'(hosts_added),
                      where: tnfp_pkg::NODE_BOTH};
               hosts_added++;
            end
         end
         default: ;
      endcase
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one transfer on the command port, then a random gap
   task automatic send_request(input request_type rq);
      outcome_type oc;
      int unsigned gap;
      @(negedge clock);
      start             <= 1'b1;
      req_operation     <= rq.op;
      req_cores         <= rq.cores;
      req_memories      <= rq.memories;
      req_dual          <= rq.dual;
      req_host_index    <= rq.host_index;
      req_release_where <= rq.release_where;
      do @(posedge clock); while (busy);
      apply_to_table(rq, oc);
      outcomes_due = {outcomes_due, oc};
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic request_type make_req(logic [1:0] op, logic [10:0] cores,
                                            logic [10:0] mem, logic dual,
                                            logic [7:0] idx, logic [1:0] where);
      return '{op: op, cores: cores, memories: mem, dual: dual,
               host_index: idx, release_where: where};
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.op            = 2'($urandom_range(0, 3));
      rq.cores         = 11'($urandom_range(0, 2047));
      rq.memories      = 11'($urandom_range(0, 2047));
      rq.dual          = 1'($urandom_range(0, 1));
      rq.host_index    = 8'($urandom_range(0, 255));
      rq.release_where = 2'($urandom_range(0, 3));
      return rq;
   endfunction

   function automatic logic [10:0] pick_amount(int unsigned lo, int unsigned hi);
      if ($urandom_range(0, 31) == 0)
         return 11'($urandom_range(0, 2047));
      return 11'($urandom_range(lo, hi));
   endfunction

   task automatic send_add();
      request_type rq;
      rq          = random_request();
      rq.op       = tnfp_pkg::OP_ADD;
      rq.cores    = pick_amount(64, 1024);
      rq.memories = pick_amount(64, 1024);
      send_request(rq);
   endtask

   task automatic send_place();
      request_type rq;
      rq    = random_request();
      rq.op = tnfp_pkg::OP_PLACE;
      if (rq.dual) begin
         rq.cores    = pick_amount(0, 512);
         rq.memories = pick_amount(0, 512);
      end else begin
         rq.cores    = pick_amount(0, 200);
         rq.memories = pick_amount(0, 200);
      end
      send_request(rq);
   endtask

   // mostly gives back an earlier placement, sometimes a stray release
   task automatic send_release();
      request_type rq;
      holding_type held;
      int unsigned pick;
      rq    = random_request();
      rq.op = tnfp_pkg::OP_RELEASE;
      if (placements_held.size() != 0 && $urandom_range(0, 3) != 0) begin
         pick = $urandom_range(0, placements_held.size() - 1);
         held = placements_held[pick];
         placements_held.delete(pick);
         rq.host_index    = held.host;
         rq.release_where = held.where;
         rq.cores         = held.cores;
         rq.memories      = held.mem;
         if (held.where == tnfp_pkg::NODE_B && $urandom_range(0, 3) == 0)
            rq.release_where = NODE_ALT_B;
      end
      send_request(rq);
   endtask

   task automatic random_mix(input int unsigned count, input int unsigned add_weight);
      request_type rq;
      int unsigned roll;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 64 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < add_weight) begin
            send_add();
         end else if (roll < add_weight + 50) begin
            send_place();
         end else if (roll < 97) begin
            send_release();
         end else begin
            rq    = random_request();
            rq.op = OP_NONE;
            send_request(rq);
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic test_empty_table();
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd10, 11'd10, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd2047, 11'd2047, 1'b1, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd5, 11'd5, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd2047, 11'd2047, 1'b1, 8'd255,
                            tnfp_pkg::NODE_BOTH));
      send_request(make_req(OP_NONE, 11'd2047, 11'd2047, 1'b1, 8'd255, NODE_ALT_B));
   endtask

   task automatic test_directed_cases();
      send_request(make_req(tnfp_pkg::OP_ADD, 11'd0, 11'd0, 1'b0, 8'd0, tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_ADD, 11'd2047, 11'd2047, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_ADD, 11'd1024, 11'd1024, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_ADD, 11'd1, 11'd3, 1'b0, 8'd0, tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd0, 11'd0, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      // equal nodes go to B, then A has more free cores
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd5, 11'd5, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd5, 11'd5, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd2047, 11'd2047, 1'b1, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd1024, 11'd1024, 1'b1, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd2047, 11'd2047, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd1024, 11'd1024, 1'b0, 8'd1,
                            tnfp_pkg::NODE_BOTH));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd2047, 11'd2047, 1'b0, 8'd1,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd2047, 11'd0, 1'b0, 8'd1,
                            NODE_ALT_B));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd7, 11'd7, 1'b0, 8'd4,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_RELEASE, 11'd0, 11'd0, 1'b0, 8'd2,
                            tnfp_pkg::NODE_B));
      send_request(make_req(tnfp_pkg::OP_ADD, 11'd2046, 11'd1, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd1023, 11'd0, 1'b0, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(tnfp_pkg::OP_PLACE, 11'd1, 11'd1, 1'b1, 8'd0,
                            tnfp_pkg::NODE_A));
      send_request(make_req(OP_NONE, 11'd0, 11'd0, 1'b0, 8'd0, tnfp_pkg::NODE_A));
   endtask

   task automatic test_random_growth();
      random_mix(900, 15);
   endtask

   task automatic test_table_full();
      while (hosts_added < TABLE_SIZE)
         send_add();
      repeat (3) send_add();
   endtask

   task automatic test_random_full();
      random_mix(700, 3);
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      outcome_type oc;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("unexpected response status", rsp_status, 0);
         end else begin
            oc = outcomes_due.pop_front();
            if (rsp_status !== oc.status)
               report_mismatch("status", rsp_status, oc.status);
            if (rsp_placed_host !== oc.host)
               report_mismatch("placed_host", rsp_placed_host, oc.host);
            if (rsp_placed_where !== oc.where)
               report_mismatch("placed_where", rsp_placed_where, oc.where);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("two_node_first_fit_placer_unit_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_operation     = tnfp_pkg::OP_PLACE;
      req_cores         = '0;
      req_memories      = '0;
      req_dual          = 1'b0;
      req_host_index    = '0;
      req_release_where = tnfp_pkg::NODE_A;
      hosts_added       = 0;
      mismatches        = 0;
      idle_cycles       = 0;
      no_idle           = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_directed_cases();
      test_random_growth();
      test_table_full();
      test_random_full();

      @(negedge clock);
      start <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("two_node_first_fit_placer_unit_tb OK");
      else
         $display("two_node_first_fit_placer_unit_tb NOT OK");
      $finish;
   end

endmodule
